@@ rtl/core/fsc_pkg.sv @@
// Shared types, widths, register indexes and width helpers for the frustum sphere cull block.
package fsc_pkg;

    // Fixed field widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_W          = 16;   // Q2.14 coefficients
    localparam int TRANS_W         = 21;   // Q17.4 translation terms
    localparam int DEPTH_W         = 32;   // Q28.4 depths
    localparam int RADIUS_W        = 31;   // Q27.4 unsigned radius
    localparam int FRAC_SHIFT      = 14;   // Q*.4 -> Q*.18 alignment
    localparam int RADIUS_SHIFT    = 28;   // radius scale against plane distance
    localparam int ROW_W           = 3 * COEF_W;
    localparam int TRANS_REG_W     = 3 * TRANS_W;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_FAR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LR  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_TB  = 3'd6;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]  rows;
        logic [TRANS_REG_W-1:0] trans;
    } cam_cfg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] depths;
        logic [CFG_DATA_W-1:0] lr;
        logic [CFG_DATA_W-1:0] tb;
    } plane_cfg_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Camera-space coordinate: three products plus shifted translation
    function automatic int cam_width(input int cw);
        return max_int(cw + COEF_W, TRANS_W + FRAC_SHIFT) + 2;
    endfunction

    // Depth compare width: coordinate against shifted depth and shifted radius
    function automatic int depth_width(input int pw);
        return max_int(pw, DEPTH_W + FRAC_SHIFT) + 2;
    endfunction

    // Plane distance compare width: sum of two products against shifted radius
    function automatic int dist_width(input int pw);
        return max_int(pw + COEF_W + 1, RADIUS_W + RADIUS_SHIFT + 1) + 1;
    endfunction

endpackage

@@ rtl/core/fsc_cam_xform.sv @@
// Two-stage camera transform: coefficient products, then row sums with translation.
module fsc_cam_xform #(
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic [COORD_WIDTH-1:0]              center_x,
    input  logic [COORD_WIDTH-1:0]              center_y,
    input  logic [COORD_WIDTH-1:0]              center_z,
    input  logic [fsc_pkg::RADIUS_W-1:0]        radius,
    input  fsc_pkg::cam_cfg_t                   cfg,
    output logic                                out_valid,
    output logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_x,
    output logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_y,
    output logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_z,
    output logic [fsc_pkg::RADIUS_W-1:0]        radius_out
);

    localparam int PW  = fsc_pkg::cam_width(COORD_WIDTH);
    localparam int PRW = COORD_WIDTH + fsc_pkg::COEF_W;
    localparam int CW  = fsc_pkg::COEF_W;
    localparam int TW  = fsc_pkg::TRANS_W;

    logic [COORD_WIDTH-1:0]        coord [3];
    logic signed [PRW-1:0]         prod_reg [3][3];
    logic [fsc_pkg::RADIUS_W-1:0]  radius1_reg;
    logic                          valid1_reg;
    logic signed [PW-1:0]          cam_next [3];
    logic signed [PW-1:0]          cam_reg [3];
    logic [fsc_pkg::RADIUS_W-1:0]  radius2_reg;
    logic                          valid2_reg;

    assign coord[0] = center_x;
    assign coord[1] = center_y;
    assign coord[2] = center_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Stage 1: nine coefficient products
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r][k] <= $signed(coord[k]) * $signed(cfg.rows[r][CW*k +: CW]);
                end
            end
            radius1_reg <= radius;
        end
    end

    // Stage 2: row sums plus translation aligned to the product scale
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cam_next[r] = PW'(prod_reg[r][0]) + PW'(prod_reg[r][1]) + PW'(prod_reg[r][2])
                        + (PW'($signed(cfg.trans[TW*r +: TW])) <<< fsc_pkg::FRAC_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                cam_reg[r] <= cam_next[r];
            end
            radius2_reg <= radius1_reg;
        end
    end

    assign out_valid  = valid2_reg;
    assign cam_x      = cam_reg[0];
    assign cam_y      = cam_reg[1];
    assign cam_z      = cam_reg[2];
    assign radius_out = radius2_reg;

endmodule

@@ rtl/core/fsc_plane_test.sv @@
// Two-stage plane tests: depth compares and normal products, then distance compares.
module fsc_plane_test #(
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_x,
    input  logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_y,
    input  logic signed [fsc_pkg::cam_width(COORD_WIDTH)-1:0] cam_z,
    input  logic [fsc_pkg::RADIUS_W-1:0]        radius,
    input  fsc_pkg::plane_cfg_t                 cfg,
    output logic                                out_valid,
    output logic                                out_vis
);

    localparam int PW  = fsc_pkg::cam_width(COORD_WIDTH);
    localparam int ZW  = fsc_pkg::depth_width(PW);
    localparam int DW  = fsc_pkg::dist_width(PW);
    localparam int NPW = PW + fsc_pkg::COEF_W;
    localparam int CW  = fsc_pkg::COEF_W;
    localparam int DPW = fsc_pkg::DEPTH_W;

    logic signed [ZW-1:0]          z_ext;
    logic signed [ZW-1:0]          r14_ext;
    logic signed [ZW-1:0]          near_ext;
    logic signed [ZW-1:0]          far_ext;
    logic                          near_rej_next;
    logic                          far_rej_next;
    logic signed [PW-1:0]          opnd [8];
    logic signed [CW-1:0]          coef [8];
    logic signed [NPW-1:0]         nprod_reg [8];
    logic                          near_rej_reg;
    logic                          far_rej_reg;
    logic [fsc_pkg::RADIUS_W-1:0]  radius3_reg;
    logic                          valid3_reg;
    logic signed [DW-1:0]          r28_ext;
    logic signed [DW-1:0]          side_dist [4];
    logic                          side_rej;
    logic                          vis_reg;
    logic                          valid4_reg;

    // Stage 3: depth tests against the shifted near and far values
    always_comb begin
        z_ext         = ZW'(cam_z);
        r14_ext       = ZW'({radius, {fsc_pkg::FRAC_SHIFT{1'b0}}});
        near_ext      = ZW'($signed(cfg.depths[DPW-1:0])) <<< fsc_pkg::FRAC_SHIFT;
        far_ext       = ZW'($signed(cfg.depths[2*DPW-1:DPW])) <<< fsc_pkg::FRAC_SHIFT;
        near_rej_next = (z_ext - r14_ext) > near_ext;
        far_rej_next  = far_ext > (z_ext + r14_ext);
    end

    // Side-plane operands: left, right, top, bottom, each as (side, z) pairs
    assign opnd = '{cam_x, cam_z, cam_x, cam_z, cam_y, cam_z, cam_y, cam_z};
    assign coef = '{$signed(cfg.lr[CW-1:0]),      $signed(cfg.lr[2*CW-1:CW]),
                    $signed(cfg.lr[3*CW-1:2*CW]), $signed(cfg.lr[4*CW-1:3*CW]),
                    $signed(cfg.tb[CW-1:0]),      $signed(cfg.tb[2*CW-1:CW]),
                    $signed(cfg.tb[3*CW-1:2*CW]), $signed(cfg.tb[4*CW-1:3*CW])};

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 8; i++) begin
                nprod_reg[i] <= opnd[i] * coef[i];
            end
            near_rej_reg <= near_rej_next;
            far_rej_reg  <= far_rej_next;
            radius3_reg  <= radius;
        end
    end

    // Stage 4: plane distances against the radius at the distance scale
    always_comb begin
        r28_ext = DW'({radius3_reg, {fsc_pkg::RADIUS_SHIFT{1'b0}}});
        for (int j = 0; j < 4; j++) begin
            side_dist[j] = DW'(nprod_reg[2*j]) + DW'(nprod_reg[2*j+1]);
        end
        side_rej = (side_dist[0] > r28_ext) || (side_dist[1] > r28_ext)
                || (side_dist[2] > r28_ext) || (side_dist[3] > r28_ext);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            vis_reg <= !(near_rej_reg || far_rej_reg || side_rej);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else if (advance) begin
            valid3_reg <= in_valid;
            valid4_reg <= valid3_reg;
        end
    end

    assign out_valid = valid4_reg;
    assign out_vis   = vis_reg;

endmodule

@@ rtl/core/frustum_sphere_cull_top.sv @@
// Top level of the frustum sphere cull block: configuration registers and pipeline control.
//
// Takes one bounding sphere per transfer and returns one may_be_visible flag per sphere,
// in order. The sustained rate is one sphere per clock cycle while the result side does
// not stall. The four stages are the camera coefficient products, the camera row sums,
// the depth compares together with the side-plane products, and the plane distance
// compares that load the output register. The whole pipeline advances as one: when a
// result waits in the output register and m_ready is low, every stage holds and s_ready
// drops, so no item is lost or repeated. Configuration registers are written through
// the cfg channel, which is always ready; write them only while no sphere is in flight.
// An index beyond the last register is ignored. COORD_WIDTH sets how many bits of each
// center coordinate are used; all arithmetic is kept at full width, so nothing saturates
// or rounds.
module frustum_sphere_cull_top #(
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sphere input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [COORD_WIDTH-1:0]              s_center_x,
    input  logic [COORD_WIDTH-1:0]              s_center_y,
    input  logic [COORD_WIDTH-1:0]              s_center_z,
    input  logic [fsc_pkg::RADIUS_W-1:0]        s_radius,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_may_be_visible,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int PW = fsc_pkg::cam_width(COORD_WIDTH);

    logic [fsc_pkg::ROW_W-1:0]        row0_reg;
    logic [fsc_pkg::ROW_W-1:0]        row1_reg;
    logic [fsc_pkg::ROW_W-1:0]        row2_reg;
    logic [fsc_pkg::TRANS_REG_W-1:0]  trans_reg;
    logic [fsc_pkg::CFG_DATA_W-1:0]   depths_reg;
    logic [fsc_pkg::CFG_DATA_W-1:0]   lr_reg;
    logic [fsc_pkg::CFG_DATA_W-1:0]   tb_reg;

    fsc_pkg::cam_cfg_t                cam_cfg;
    fsc_pkg::plane_cfg_t              plane_cfg;

    logic                             advance;
    logic                             xf_valid;
    logic signed [PW-1:0]             cam_x;
    logic signed [PW-1:0]             cam_y;
    logic signed [PW-1:0]             cam_z;
    logic [fsc_pkg::RADIUS_W-1:0]     xf_radius;

    // The config channel never stalls
    assign cfg_ready = 1'b1;

    // Decode the register index and drop bits above each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg   <= '0;
            row1_reg   <= '0;
            row2_reg   <= '0;
            trans_reg  <= '0;
            depths_reg <= '0;
            lr_reg     <= '0;
            tb_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fsc_pkg::REG_ROW0:     row0_reg   <= cfg_data[fsc_pkg::ROW_W-1:0];
                fsc_pkg::REG_ROW1:     row1_reg   <= cfg_data[fsc_pkg::ROW_W-1:0];
                fsc_pkg::REG_ROW2:     row2_reg   <= cfg_data[fsc_pkg::ROW_W-1:0];
                fsc_pkg::REG_TRANS:    trans_reg  <= cfg_data[fsc_pkg::TRANS_REG_W-1:0];
                fsc_pkg::REG_NEAR_FAR: depths_reg <= cfg_data;
                fsc_pkg::REG_SIDE_LR:  lr_reg     <= cfg_data;
                fsc_pkg::REG_SIDE_TB:  tb_reg     <= cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    assign cam_cfg.rows   = {row2_reg, row1_reg, row0_reg};
    assign cam_cfg.trans  = trans_reg;
    assign plane_cfg.depths = depths_reg;
    assign plane_cfg.lr     = lr_reg;
    assign plane_cfg.tb     = tb_reg;

    // Advance every stage unless a finished result is held by the result side
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    fsc_cam_xform #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cam_xform (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_valid),
        .center_x   (s_center_x),
        .center_y   (s_center_y),
        .center_z   (s_center_z),
        .radius     (s_radius),
        .cfg        (cam_cfg),
        .out_valid  (xf_valid),
        .cam_x      (cam_x),
        .cam_y      (cam_y),
        .cam_z      (cam_z),
        .radius_out (xf_radius)
    );

    fsc_plane_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_plane_test (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (xf_valid),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z),
        .radius    (xf_radius),
        .cfg       (plane_cfg),
        .out_valid (m_valid),
        .out_vis   (m_may_be_visible)
    );

    // An accepted sphere reaches the output while m_ready stays high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("accepted sphere did not reach the output in four cycles");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A depth register write lands with the written data
    a_cfg_depths: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == fsc_pkg::REG_NEAR_FAR)
        |=> depths_reg == $past(cfg_data))
        else $error("near/far register write lost");

endmodule
